// File: rtl/sdz_pkg.sv
// Shared constants for the stick radial dead-zone calibration block.
// Holds the configuration register indexes; no dependencies.
`timescale 1ns / 1ps

package sdz_pkg;

    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_CENTER_X    = 3'd0;
    localparam cfg_idx_t CFG_CENTER_Y    = 3'd1;
    localparam cfg_idx_t CFG_RANGE_X     = 3'd2;
    localparam cfg_idx_t CFG_RANGE_Y     = 3'd3;
    localparam cfg_idx_t CFG_DRIFT_THR   = 3'd4;

endpackage

// File: rtl/stick_radial_deadzone_calibrate.sv
// Top level of the stick radial dead-zone calibration pipeline.
// Uses sdz_pkg for register indexes.
//
//   channel   signals                                   handshake
//   input     start, busy, x_in, y_in                   start && !busy
//   result    result_valid, x_out, y_out                strobe, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// One item enters every cycle; busy is always low.
// The pipeline holds a per-bit divider, a square root and a scaling divider
// of SAMPLE_WIDTH+1, SAMPLE_WIDTH and SAMPLE_WIDTH steps.
// Reset clears the valid chain and loads the register defaults.
// The receiver cannot stall, so results leave at the rate items enter.
`timescale 1ns / 1ps

module stick_radial_deadzone_calibrate #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    input  logic signed [SAMPLE_WIDTH-1:0] y_in,
    output logic                           result_valid,
    output logic signed [SAMPLE_WIDTH-1:0] x_out,
    output logic signed [SAMPLE_WIDTH-1:0] y_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  sdz_pkg::cfg_idx_t              cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]        cfg_data
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int F   = W - 1;
    localparam int NQ  = F + 2;
    localparam int NS  = F + 1;
    localparam int RW  = F + 4;
    localparam int MW  = F + 2;
    localparam int SW  = 2 * F + 2;
    localparam int LAT = NQ + 5 + 2 * NS;
    localparam logic [F:0]    ONE_C    = {1'b1, {F{1'b0}}};
    localparam logic [F:0]    ONE_M1   = {1'b0, {F{1'b1}}};
    localparam logic [SW-1:0] ONE_SQ   = {2'b01, {(2 * F){1'b0}}};
    localparam logic [F-1:0]  RANGE_ONE = {{(F - 1){1'b0}}, 1'b1};

    logic [W-1:0]     center_reg [2];
    logic [F-1:0]     range_reg [2];
    logic [F-1:0]     thr_reg;
    logic [2*F-1:0]   thr_sq_reg;
    logic [LAT-1:0]   valid_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            range_reg[0]  <= '1;
            range_reg[1]  <= '1;
            thr_reg       <= '0;
            valid_reg     <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], start};
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sdz_pkg::CFG_CENTER_X:  center_reg[0] <= cfg_data;
                    sdz_pkg::CFG_CENTER_Y:  center_reg[1] <= cfg_data;
                    sdz_pkg::CFG_RANGE_X:   range_reg[0] <= (cfg_data[F-1:0] == '0) ?
                                                RANGE_ONE : cfg_data[F-1:0];
                    sdz_pkg::CFG_RANGE_Y:   range_reg[1] <= (cfg_data[F-1:0] == '0) ?
                                                RANGE_ONE : cfg_data[F-1:0];
                    sdz_pkg::CFG_DRIFT_THR: thr_reg <= cfg_data[F-1:0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        thr_sq_reg <= thr_reg * thr_reg;
    end

    // Input stage: offset removal and overflow check of the axis quotient.
    logic [W-1:0]   in_a [2];
    logic [F-1:0]   s0_r_reg [2];
    logic [1:0]     s0_lo_reg [2];
    logic           s0_neg_reg [2];
    logic           s0_ovf_reg [2];

    assign in_a[0] = x_in;
    assign in_a[1] = y_in;

    for (genvar a = 0; a < 2; a++)
    begin : g_in
        logic signed [W:0] d;
        logic [W-1:0]      mag;

        always_comb
        begin
            d   = $signed({in_a[a][W-1], in_a[a]}) -
                  $signed({center_reg[a][W-1], center_reg[a]});
            mag = d[W] ? W'(-d) : d[W-1:0];
        end

        always_ff @(posedge clk)
        begin
            s0_r_reg[a]   <= {1'b0, mag[W-1:2]};
            s0_lo_reg[a]  <= mag[1:0];
            s0_neg_reg[a] <= d[W];
            s0_ovf_reg[a] <= mag >= {range_reg[a], 1'b0};
        end
    end

    // Axis divider, one quotient bit per stage.
    logic [F-1:0]   dv_r_reg [NQ][2];
    logic [F+1:0]   dv_q_reg [NQ][2];
    logic [1:0]     dv_lo_reg [NQ][2];
    logic           dv_neg_reg [NQ][2];
    logic           dv_ovf_reg [NQ][2];

    for (genvar k = 0; k < NQ; k++)
    begin : g_dv
        for (genvar a = 0; a < 2; a++)
        begin : g_ax
            logic [F-1:0] r_src;
            logic [F+1:0] q_src;
            logic [1:0]   lo_src;
            logic         neg_src;
            logic         ovf_src;
            logic         nbit;
            logic [F:0]   t;
            logic         ge;

            if (k == 0)
            begin : g_first
                assign r_src   = s0_r_reg[a];
                assign q_src   = '0;
                assign lo_src  = s0_lo_reg[a];
                assign neg_src = s0_neg_reg[a];
                assign ovf_src = s0_ovf_reg[a];
            end
            else
            begin : g_next
                assign r_src   = dv_r_reg[k-1][a];
                assign q_src   = dv_q_reg[k-1][a];
                assign lo_src  = dv_lo_reg[k-1][a];
                assign neg_src = dv_neg_reg[k-1][a];
                assign ovf_src = dv_ovf_reg[k-1][a];
            end

            always_comb
            begin
                nbit = (k == 0) ? lo_src[1] : ((k == 1) ? lo_src[0] : 1'b0);
                t    = {r_src, nbit};
                ge   = t >= {1'b0, range_reg[a]};
            end

            always_ff @(posedge clk)
            begin
                dv_r_reg[k][a]   <= ge ? F'(t - {1'b0, range_reg[a]}) : t[F-1:0];
                dv_q_reg[k][a]   <= {q_src[F:0], ge};
                dv_lo_reg[k][a]  <= lo_src;
                dv_neg_reg[k][a] <= neg_src;
                dv_ovf_reg[k][a] <= ovf_src;
            end
        end
    end

    // Clamp and square.
    logic [F:0]     cs_c_reg [2];
    logic [2*F:0]   cs_sq_reg [2];
    logic           cs_neg_reg [2];

    for (genvar a = 0; a < 2; a++)
    begin : g_cs
        logic [F:0] c;

        always_comb
        begin
            c = (dv_ovf_reg[NQ-1][a] || dv_q_reg[NQ-1][a] > {1'b0, ONE_C}) ?
                ONE_C : dv_q_reg[NQ-1][a][F:0];
        end

        always_ff @(posedge clk)
        begin
            cs_c_reg[a]   <= c;
            cs_sq_reg[a]  <= (2 * F + 1)'(c * c);
            cs_neg_reg[a] <= dv_neg_reg[NQ-1][a];
        end
    end

    // Sum of squares and region decision.
    logic [SW-1:0]  sm_s_reg;
    logic [F:0]     sm_c_reg [2];
    logic           sm_neg_reg [2];
    logic           sm_out_reg;
    logic           sm_dead_reg;
    logic [SW-1:0]  s_sum;

    always_comb
    begin
        s_sum = {1'b0, cs_sq_reg[0]} + {1'b0, cs_sq_reg[1]};
    end

    always_ff @(posedge clk)
    begin
        sm_s_reg    <= s_sum;
        sm_c_reg    <= cs_c_reg;
        sm_neg_reg  <= cs_neg_reg;
        sm_out_reg  <= s_sum > ONE_SQ;
        sm_dead_reg <= (s_sum <= ONE_SQ) && (s_sum <= {2'b00, thr_sq_reg});
    end

    // Square root, one result bit per stage.
    logic [RW-1:0]  sq_rem_reg [NS];
    logic [F:0]     sq_root_reg [NS];
    logic [SW-1:0]  sq_s_reg [NS];
    logic [F:0]     sq_c_reg [NS][2];
    logic           sq_neg_reg [NS][2];
    logic           sq_out_reg [NS];
    logic           sq_dead_reg [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_sq
        logic [RW-1:0] rem_src;
        logic [F:0]    root_src;
        logic [SW-1:0] s_src;
        logic [F:0]    c_src [2];
        logic          neg_src [2];
        logic          out_src;
        logic          dead_src;
        logic [RW-1:0] rem_t;
        logic [RW-1:0] trial;
        logic          ge;

        if (j == 0)
        begin : g_first
            assign rem_src  = '0;
            assign root_src = '0;
            assign s_src    = sm_s_reg;
            assign c_src    = sm_c_reg;
            assign neg_src  = sm_neg_reg;
            assign out_src  = sm_out_reg;
            assign dead_src = sm_dead_reg;
        end
        else
        begin : g_next
            assign rem_src  = sq_rem_reg[j-1];
            assign root_src = sq_root_reg[j-1];
            assign s_src    = sq_s_reg[j-1];
            assign c_src    = sq_c_reg[j-1];
            assign neg_src  = sq_neg_reg[j-1];
            assign out_src  = sq_out_reg[j-1];
            assign dead_src = sq_dead_reg[j-1];
        end

        always_comb
        begin
            rem_t = {rem_src[RW-3:0], s_src[2*(F-j)+1 -: 2]};
            trial = RW'({root_src, 2'b01});
            ge    = rem_t >= trial;
        end

        always_ff @(posedge clk)
        begin
            sq_rem_reg[j]  <= ge ? rem_t - trial : rem_t;
            sq_root_reg[j] <= {root_src[F-1:0], ge};
            sq_s_reg[j]    <= s_src;
            sq_c_reg[j]    <= c_src;
            sq_neg_reg[j]  <= neg_src;
            sq_out_reg[j]  <= out_src;
            sq_dead_reg[j] <= dead_src;
        end
    end

    // Rounded-up magnitude; inside the circle the scale divisor is one.
    logic [MW-1:0]  ce_m_reg;
    logic [F:0]     ce_c_reg [2];
    logic           ce_neg_reg [2];
    logic           ce_dead_reg;

    always_ff @(posedge clk)
    begin
        ce_m_reg    <= sq_out_reg[NS-1] ?
                       MW'({1'b0, sq_root_reg[NS-1]} + MW'(sq_rem_reg[NS-1] != '0)) :
                       MW'(ONE_C);
        ce_c_reg    <= sq_c_reg[NS-1];
        ce_neg_reg  <= sq_neg_reg[NS-1];
        ce_dead_reg <= sq_dead_reg[NS-1];
    end

    // Scaling divider onto the unit circle, one quotient bit per stage.
    logic [MW-1:0]  sh_r_reg [NS][2];
    logic [F:0]     sh_q_reg [NS][2];
    logic           sh_lo_reg [NS][2];
    logic           sh_neg_reg [NS][2];
    logic [MW-1:0]  sh_m_reg [NS];
    logic           sh_dead_reg [NS];

    for (genvar k = 0; k < NS; k++)
    begin : g_sh
        logic [MW-1:0] m_src;
        logic          dead_src;

        if (k == 0)
        begin : g_first_m
            assign m_src    = ce_m_reg;
            assign dead_src = ce_dead_reg;
        end
        else
        begin : g_next_m
            assign m_src    = sh_m_reg[k-1];
            assign dead_src = sh_dead_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            sh_m_reg[k]    <= m_src;
            sh_dead_reg[k] <= dead_src;
        end

        for (genvar a = 0; a < 2; a++)
        begin : g_ax
            logic [MW-1:0] r_src;
            logic [F:0]    q_src;
            logic          lo_src;
            logic          neg_src;
            logic [MW:0]   t;
            logic          ge;

            if (k == 0)
            begin : g_first
                assign r_src   = MW'(ce_c_reg[a][F:1]);
                assign q_src   = '0;
                assign lo_src  = ce_c_reg[a][0];
                assign neg_src = ce_neg_reg[a];
            end
            else
            begin : g_next
                assign r_src   = sh_r_reg[k-1][a];
                assign q_src   = sh_q_reg[k-1][a];
                assign lo_src  = sh_lo_reg[k-1][a];
                assign neg_src = sh_neg_reg[k-1][a];
            end

            always_comb
            begin
                t  = {r_src, (k == 0) ? lo_src : 1'b0};
                ge = t >= {1'b0, m_src};
            end

            always_ff @(posedge clk)
            begin
                sh_r_reg[k][a]   <= ge ? MW'(t - {1'b0, m_src}) : t[MW-1:0];
                sh_q_reg[k][a]   <= {q_src[F-1:0], ge};
                sh_lo_reg[k][a]  <= lo_src;
                sh_neg_reg[k][a] <= neg_src;
            end
        end
    end

    // Output stage: dead zone, sign and saturation.
    logic [W-1:0] out_reg [2];

    for (genvar a = 0; a < 2; a++)
    begin : g_out
        logic [F:0] q;

        assign q = sh_q_reg[NS-1][a];

        always_ff @(posedge clk)
        begin
            priority if (sh_dead_reg[NS-1])
                out_reg[a] <= '0;
            else if (sh_neg_reg[NS-1][a])
                out_reg[a] <= W'(~q + 1'b1);
            else if (q == ONE_C)
                out_reg[a] <= ONE_M1;
            else
                out_reg[a] <= q;
        end
    end

    assign result_valid = valid_reg[LAT-1];
    assign x_out        = out_reg[0];
    assign y_out        = out_reg[1];

`ifndef ASSERT_OFF
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, LAT))
        else $error("result without an item accepted LAT cycles earlier");

    a_range_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        range_reg[0] != '0 && range_reg[1] != '0)
        else $error("range register holds zero");

    a_dead_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAT-2] && sh_dead_reg[NS-1]) |=> (x_out == '0 && y_out == '0))
        else $error("dead-zone item gave a nonzero result");

    a_scale_min : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NQ + 3 + NS] |-> ce_m_reg >= MW'(ONE_C))
        else $error("scale divisor below one");
`endif

endmodule

// File: test/sdz_checker.sv
// Checker for the stick radial dead-zone calibration block: predicts each result
// from the accepted samples and the register writes, then compares. Uses sdz_pkg.
`timescale 1ns / 1ps

module sdz_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    input  logic signed [SAMPLE_WIDTH-1:0] y_in,
    input  logic                           result_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] x_out,
    input  logic signed [SAMPLE_WIDTH-1:0] y_out,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  sdz_pkg::cfg_idx_t              cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]        cfg_data,
    output int                             fail_count,
    output int                             pending
);

    localparam longint ONE = 64'sd1 << (SAMPLE_WIDTH - 1);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic signed [SAMPLE_WIDTH-1:0] y;
    } axes_t;

    logic signed [SAMPLE_WIDTH-1:0] cen_x, cen_y;
    logic [SAMPLE_WIDTH-2:0] rng_x, rng_y, thr;
    axes_t calibrated_q[$];

    function automatic longint norm_axis(longint raw, longint cen, longint rng);
        longint d, mag, q, dv;
        d = raw - cen;
        mag = d < 0 ? -d : d;
        dv = rng == 0 ? 1 : rng;
        q = (mag * ONE) / dv;
        if (q > ONE)
            q = ONE;
        return d < 0 ? -q : q;
    endfunction

    function automatic longint ceil_root(longint s);
        longint r;
        r = longint'($floor($sqrt(real'(s))));
        while (r * r > s)
            r--;
        while ((r + 1) * (r + 1) <= s)
            r++;
        if (r * r < s)
            r++;
        return r;
    endfunction

    function automatic longint shrink(longint c, longint m);
        longint q;
        q = ((c < 0 ? -c : c) * ONE) / m;
        return c < 0 ? -q : q;
    endfunction

    function automatic axes_t calibrate(longint xi, longint yi);
        longint cx, cy, s, m;
        logic dead;
        axes_t r;
        cx = norm_axis(xi, longint'(cen_x), longint'(rng_x));
        cy = norm_axis(yi, longint'(cen_y), longint'(rng_y));
        s = cx * cx + cy * cy;
        if (s > ONE * ONE) begin
            m = ceil_root(s);
            cx = shrink(cx, m);
            cy = shrink(cy, m);
            dead = ONE <= longint'(thr);
        end
        else begin
            dead = s <= longint'(thr) * longint'(thr);
        end
        if (dead) begin
            cx = 0;
            cy = 0;
        end
        if (cx > ONE - 1)
            cx = ONE - 1;
        if (cy > ONE - 1)
            cy = ONE - 1;
        r.x = cx[SAMPLE_WIDTH-1:0];
        r.y = cy[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

    assign pending = calibrated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        axes_t e;
        if (!rst_n) begin
            cen_x = '0;
            cen_y = '0;
            rng_x = '1;
            rng_y = '1;
            thr = '0;
            fail_count = 0;
            calibrated_q.delete();
        end
        else begin
            if (result_valid) begin
                if (calibrated_q.size() == 0) begin
                    $error("unexpected result x_out=%0d y_out=%0d", x_out, y_out);
                    fail_count++;
                end
                else begin
                    e = calibrated_q.pop_front();
                    if (x_out !== e.x) begin
                        $error("x_out expected %0d actual %0d", e.x, x_out);
                        fail_count++;
                    end
                    if (y_out !== e.y) begin
                        $error("y_out expected %0d actual %0d", e.y, y_out);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                calibrated_q.push_back(calibrate(longint'(x_in), longint'(y_in)));
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sdz_pkg::CFG_CENTER_X: cen_x = cfg_data;
                    sdz_pkg::CFG_CENTER_Y: cen_y = cfg_data;
                    sdz_pkg::CFG_RANGE_X: rng_x = cfg_data[SAMPLE_WIDTH-2:0];
                    sdz_pkg::CFG_RANGE_Y: rng_y = cfg_data[SAMPLE_WIDTH-2:0];
                    sdz_pkg::CFG_DRIFT_THR: thr = cfg_data[SAMPLE_WIDTH-2:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: test/tb_stick_radial_deadzone_calibrate.sv
// Testbench top for the stick radial dead-zone calibration block: drives samples
// and register writes, and reports the verdict. Uses sdz_pkg and sdz_checker.
`timescale 1ns / 1ps

module tb_stick_radial_deadzone_calibrate;

    localparam int SW = 16;
    localparam int LAT = 3 * SW + 6;
    localparam longint LIMIT = 400000;

    logic clk = 0, rst_n = 0, start = 0, cfg_valid = 0;
    logic busy, result_valid, cfg_ready;
    logic signed [SW-1:0] x_in = '0, y_in = '0, x_out, y_out;
    sdz_pkg::cfg_idx_t cfg_index = sdz_pkg::CFG_CENTER_X;
    logic [SW-1:0] cfg_data = '0;
    int fail_count, pending, idle_pct;
    longint cycles = 0;

    stick_radial_deadzone_calibrate #(.SAMPLE_WIDTH(SW)) dut (.*);
    sdz_checker #(.SAMPLE_WIDTH(SW)) chk (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(sdz_pkg::cfg_idx_t idx, logic [SW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    task automatic send(logic [SW-1:0] xv, logic [SW-1:0] yv);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge clk);
        end
        start <= 1;
        x_in <= xv;
        y_in <= yv;
        do @(posedge clk); while (busy);
    endtask

    task automatic stop();
        @(negedge clk);
        start <= 0;
    endtask

    function automatic logic [SW-1:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return SW'($urandom_range(600) - 300);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic random_config();
        write_reg(sdz_pkg::CFG_CENTER_X, $urandom_range(1) ?
                  SW'($urandom) : SW'($urandom_range(4000) - 2000));
        write_reg(sdz_pkg::CFG_CENTER_Y, $urandom_range(1) ?
                  SW'($urandom) : SW'($urandom_range(4000) - 2000));
        write_reg(sdz_pkg::CFG_RANGE_X, $urandom_range(3) == 0 ?
                  SW'($urandom) : SW'(16'h4000 + $urandom_range(16383)));
        write_reg(sdz_pkg::CFG_RANGE_Y, $urandom_range(3) == 0 ?
                  SW'($urandom) : SW'(16'h4000 + $urandom_range(16383)));
        write_reg(sdz_pkg::CFG_DRIFT_THR, $urandom_range(2) == 0 ?
                  SW'($urandom) : SW'($urandom_range(3000)));
    endtask

    initial
    begin
        idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed samples under reset registers.
        send(16'h8000, 16'h8000);
        send(16'h7fff, 16'h7fff);
        send(16'h7fff, 16'h0000);
        send(16'h8000, 16'h0000);
        send(16'h0000, 16'h8000);
        send(16'h0000, 16'h0000);
        send(16'h5a82, 16'h5a82);
        send(16'hffff, 16'h0001);
        stop();
        drain();
        // Zero ranges act as one, a threshold reaches just short of the unit circle,
        // and an unknown index is ignored.
        write_reg(sdz_pkg::CFG_RANGE_X, 16'h8000);
        write_reg(sdz_pkg::CFG_RANGE_Y, 16'h0000);
        write_reg(sdz_pkg::CFG_DRIFT_THR, 16'hffff);
        write_reg(sdz_pkg::cfg_idx_t'(5), 16'h1234);
        write_reg(sdz_pkg::cfg_idx_t'(7), 16'h0001);
        send(16'h0001, 16'hffff);
        send(16'h0000, 16'h0000);
        send(16'h7fff, 16'h8000);
        stop();
        drain();
        write_reg(sdz_pkg::CFG_CENTER_X, 16'h7fff);
        write_reg(sdz_pkg::CFG_CENTER_Y, 16'h8000);
        write_reg(sdz_pkg::CFG_RANGE_X, 16'h0001);
        write_reg(sdz_pkg::CFG_RANGE_Y, 16'h7fff);
        write_reg(sdz_pkg::CFG_DRIFT_THR, 16'h0100);
        send(16'h8000, 16'h7fff);
        send(16'h7fff, 16'h8000);
        send(16'h7ffe, 16'h8100);
        send(16'h7f00, 16'h80ff);
        stop();
        drain();
        write_reg(sdz_pkg::CFG_CENTER_X, 16'h0000);
        write_reg(sdz_pkg::CFG_CENTER_Y, 16'h0000);
        write_reg(sdz_pkg::CFG_RANGE_X, 16'h4000);
        write_reg(sdz_pkg::CFG_RANGE_Y, 16'h7fff);
        write_reg(sdz_pkg::CFG_DRIFT_THR, 16'h7fff);
        send(16'h2000, 16'h0000);
        send(16'h6000, 16'h6000);
        send(16'h0100, 16'h0100);
        stop();
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            idle_pct = ph < 4 ? 17 : (ph < 8 ? 74 : 0);
            random_config();
            for (int i = 0; i < 58; i++) begin
                send(rand_axis(), rand_axis());
                if (i == 30) begin
                    stop();
                    while (pending != 0)
                        @(posedge clk);
                end
            end
            stop();
            drain();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
